@@ hdl/dsrm_pkg.sv @@
// ----------------------------------------------------------------------------
// dsrm_pkg
// Shared types and constants for the dot-star pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package dsrm_pkg;

  localparam int MAX_TOKENS_DEF = 16;
  localparam int KIND_W         = 2;
  localparam int SYMBOL_W       = 8;

  // wildcard token byte
  localparam logic [SYMBOL_W-1:0] DOT_SYMBOL = 8'd46;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_APPEND  = 2'd1,
    KIND_TEXT    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef struct packed {
    logic full_match;
    logic pattern_overflow;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/dsrm_if.sv @@
// ----------------------------------------------------------------------------
// dsrm_in_if / dsrm_out_if
// Valid/ready channels carrying the matcher's input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsrm_in_if;
  import dsrm_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SYMBOL_W-1:0] symbol;
  logic                repeat_req;

  modport source (output valid, output kind, output symbol, output repeat_req,
                  input ready);
  modport sink   (input valid, input kind, input symbol, input repeat_req,
                  output ready);
endinterface

interface dsrm_out_if;
  logic valid;
  logic ready;
  logic full_match;
  logic pattern_overflow;

  modport source (output valid, output full_match, output pattern_overflow,
                  input ready);
  modport sink   (input valid, input full_match, input pattern_overflow,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/dot_star_regex_matcher.sv @@
// ----------------------------------------------------------------------------
// dot_star_regex_matcher
// Whole-string matcher: literal/dot tokens with optional star, bit-parallel NFA.
// ----------------------------------------------------------------------------
// Each accepted word's result is registered in the output register, or in the skid slot while the output stalls.
// Throughput: one word per cycle while the skid slot is empty; the NFA step and the star closure (one
// MAX_TOKENS+1 bit carry chain) run between the input and the result register.
// A two-deep output stage keeps input ready for one word while a result waits.
// Reset: empty pattern, overflow clear, only position zero active, no result.
`default_nettype none

module dot_star_regex_matcher #(
  parameter int MAX_TOKENS = dsrm_pkg::MAX_TOKENS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  dsrm_in_if.sink     in_chan,
  dsrm_out_if.source  out_chan
);
  import dsrm_pkg::*;

  localparam int N     = MAX_TOKENS;
  localparam int CNT_W = $clog2(N + 1);

  // pattern store, only lanes below the count are meaningful
  logic [SYMBOL_W-1:0] sym_r [N];
  logic [N-1:0]        star_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [N:0]          act_r, act_nxt;
  logic                ovf_r, ovf_nxt;

  result_t out_r, out_nxt, skid_r, skid_nxt;
  logic    out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;

  logic    in_fire;
  kind_t   kind;
  logic    wr_en;
  result_t res;

  logic [N-1:0] mask_now, mask_new, star_eff;
  logic [N:0]   x, q, a_v, b_v, sum_v, carry_v;

  assign in_chan.ready = !skid_v_r;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign kind          = kind_t'(in_chan.kind);
  assign wr_en         = in_fire && (kind == KIND_APPEND) && (count_r < CNT_W'(N));

  // next pattern count and overflow
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    unique case (kind) inside
      KIND_CLEAR: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
      KIND_APPEND: begin
        if (count_r < CNT_W'(N)) begin
          count_nxt = count_r + CNT_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      KIND_TEXT, KIND_RESTART: begin
        count_nxt = count_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // one NFA step on a text word (other kinds restart at position zero), then star closure over the updated pattern
  always_comb begin
    for (int i = 0; i < N; i++) begin
      mask_now[i] = CNT_W'(i) < count_r;
      mask_new[i] = CNT_W'(i) < count_nxt;
      if ((kind == KIND_APPEND) && (count_r == CNT_W'(i))) begin
        star_eff[i] = in_chan.repeat_req & mask_new[i];
      end else begin
        star_eff[i] = star_r[i] & mask_new[i];
      end
    end

    x = '0;
    if (kind == KIND_TEXT) begin
      for (int i = 0; i < N; i++) begin
        if (act_r[i] && mask_now[i] &&
            (sym_r[i] == in_chan.symbol || sym_r[i] == DOT_SYMBOL)) begin
          if (star_r[i]) begin
            x[i] = 1'b1;
          end else begin
            x[i+1] = 1'b1;
          end
        end
      end
    end else begin
      x[0] = 1'b1;
    end

    // closure as a carry chain: active bits generate, starred tokens propagate
    q       = {star_eff, 1'b0};
    a_v     = x | q;
    b_v     = x;
    sum_v   = a_v + b_v;
    carry_v = sum_v ^ a_v ^ b_v;
    act_nxt = x | (q & carry_v);
  end

  assign res.full_match       = act_nxt[count_nxt];
  assign res.pattern_overflow = ovf_nxt;

  // output register plus skid slot
  always_comb begin
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (out_v_r && out_chan.ready) begin
      out_nxt    = skid_r;
      out_v_nxt  = skid_v_r;
      skid_v_nxt = 1'b0;
    end
    if (in_fire) begin
      if (!out_v_r || out_chan.ready) begin
        out_nxt   = res;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end
  end

  assign out_chan.valid            = out_v_r;
  assign out_chan.full_match       = out_r.full_match;
  assign out_chan.pattern_overflow = out_r.pattern_overflow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ovf_r    <= 1'b0;
      act_r    <= {{N{1'b0}}, 1'b1};
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
        ovf_r   <= ovf_nxt;
        act_r   <= act_nxt;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (wr_en && (count_r == CNT_W'(i))) begin
        sym_r[i]  <= in_chan.symbol;
        star_r[i] <= in_chan.repeat_req;
      end
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  a_ovf_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CNT_W'(N))
    else $error("overflow flag set with room left in the pattern");

  a_ovf_rises_on_append: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(in_fire && kind == KIND_APPEND))
    else $error("overflow flag set without a token append");

  a_no_active_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((act_r >> count_r) >> 1) == '0)
    else $error("active position beyond the end of the pattern");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid slot holds a word while the output register is empty");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_v_r)
    else $error("accepted word produced no result");

endmodule

`default_nettype wire
